>>> sv/spiral_pkg.sv
package spiral_pkg;

  localparam int MAX_ROWS_DEF     = 32;
  localparam int MAX_COLS_DEF     = 32;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 5;
  localparam int COUNT_W    = 6;
  localparam int TOT_W      = 2 * COUNT_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic load_en;
    logic walk_en;
    logic miss_en;
    logic capture_en;
    logic cfg_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
  } dp_stat_t;

endpackage

>>> sv/spiral_ifs.sv
interface spiral_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [spiral_pkg::ELEM_W-1:0] element_in;

  modport source (output valid, output command, output element_in, input ready);
  modport sink (input valid, input command, input element_in, output ready);
endinterface

interface spiral_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [spiral_pkg::ELEM_W-1:0] element_out;
  logic [spiral_pkg::IDX_W-1:0]      row_index;
  logic [spiral_pkg::IDX_W-1:0]      col_index;
  logic                             last_element;
  logic                             status;

  modport source (output valid, output element_out, output row_index, output col_index,
                  output last_element, output status, input ready);
  modport sink (input valid, input element_out, input row_index, input col_index,
                input last_element, input status, output ready);
endinterface

interface spiral_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spiral_pkg::CFG_IDX_W-1:0]  index;
  logic [spiral_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/spiral_order_matrix_reader_core.sv
// Channel   Direction  Payload
// in_chan   sink       command, element_in (load next element or read next spiral element)
// out_chan  source     element_out, row_index, col_index, last_element, status
// cfg_chan  sink       index, data (0 row count, 1 column count)
//
// A load gives no result; a partly loaded matrix answers a read in the cycle after acceptance.
// A spiral read passes the registered read port of the matrix memory, then the result register.
// Reset is synchronous and active low; the matrix memory is not cleared and needs no sweep.
// A full result register that is not taken holds off the next request; loads are not buffered.
module spiral_order_matrix_reader_core #(
  parameter int MAX_ROWS     = spiral_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = spiral_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = spiral_pkg::ELEMENT_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  spiral_in_if.sink    in_chan,
  spiral_out_if.source out_chan,
  spiral_cfg_if.sink   cfg_chan
);

  spiral_pkg::ctl_cmd_t cmd;
  spiral_pkg::dp_stat_t stat;

  spiral_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .cfg_valid  (cfg_chan.valid),
    .cfg_ready  (cfg_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  spiral_dp #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .element_in   (in_chan.element_in),
    .cfg_index    (cfg_chan.index),
    .cfg_data     (cfg_chan.data),
    .element_out  (out_chan.element_out),
    .row_index    (out_chan.row_index),
    .col_index    (out_chan.col_index),
    .last_element (out_chan.last_element),
    .status       (out_chan.status)
  );

endmodule

>>> sv/spiral_ctrl.sv
module spiral_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  spiral_pkg::dp_stat_t stat,
  output spiral_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cmd.load_en    = in_acc && (in_command == spiral_pkg::CMD_LOAD);
    cmd.walk_en    = in_acc && (in_command == spiral_pkg::CMD_READ) && stat.full;
    cmd.miss_en    = in_acc && (in_command == spiral_pkg::CMD_READ) && !stat.full;
    cmd.capture_en = (state_r == ST_READ);
    cmd.cfg_en     = cfg_valid && cfg_ready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.walk_en) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture_en || cmd.miss_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A spiral read only starts on a fully loaded matrix.
  a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_en |-> stat.full) else $error("spiral read started on partial matrix");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE) else $error("read state held too long");

  // The result register must be free when the memory data arrives.
  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !out_valid_r) else $error("result overwritten");

  a_capture_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture_en |-> $past(cmd.walk_en)) else $error("capture without memory read");

endmodule

>>> sv/spiral_dp.sv
module spiral_dp #(
  parameter int MAX_ROWS     = spiral_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = spiral_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = spiral_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spiral_pkg::ctl_cmd_t                 cmd,
  output spiral_pkg::dp_stat_t                 stat,
  input  logic signed [spiral_pkg::ELEM_W-1:0] element_in,
  input  logic [spiral_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spiral_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic signed [spiral_pkg::ELEM_W-1:0] element_out,
  output logic [spiral_pkg::IDX_W-1:0]         row_index,
  output logic [spiral_pkg::IDX_W-1:0]         col_index,
  output logic                                 last_element,
  output logic                                 status
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = spiral_pkg::COUNT_W;
  localparam int TW     = spiral_pkg::TOT_W;
  localparam int EW     = spiral_pkg::ELEM_W;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] v, input int maxv);
    logic [CW-1:0] res;
    res = v;
    if (v == '0) begin
      res = CW'(1);
    end else if (int'(v) > maxv) begin
      res = CW'(maxv);
    end
    return res;
  endfunction

  logic [ELEMENT_BITS-1:0] mem [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data_r;

  logic [CW-1:0] row_count_r, row_count_nxt, col_count_r, col_count_nxt;
  logic [CW-1:0] load_row_r, load_row_nxt, load_col_r, load_col_nxt;
  logic [TW-1:0] emitted_r, emitted_nxt;
  logic [CW-1:0] walk_row_r, walk_row_nxt, walk_col_r, walk_col_nxt;
  dir_t          dir_r, dir_nxt;
  logic [CW-1:0] bnd_top_r, bnd_top_nxt, bnd_bot_r, bnd_bot_nxt;
  logic [CW-1:0] bnd_left_r, bnd_left_nxt, bnd_right_r, bnd_right_nxt;

  logic          full;
  logic [TW-1:0] total;
  logic          last;
  logic          cfg_hit;
  logic          rewind;
  logic [CW-1:0] wr_row, wr_col;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   in_wide;
  logic signed [63:0] rd_ext;

  assign full      = (load_row_r == row_count_r);
  assign stat.full = full;
  assign total     = TW'(row_count_r) * TW'(col_count_r);
  assign last      = (emitted_r + TW'(1)) >= total;
  assign wr_row    = full ? '0 : load_row_r;
  assign wr_col    = full ? '0 : load_col_r;
  assign wr_addr   = AW'(int'(wr_row) * MAX_COLS + int'(wr_col));
  assign rd_addr   = AW'(int'(walk_row_r) * MAX_COLS + int'(walk_col_r));
  assign in_wide   = 64'($unsigned(element_in));
  assign rd_ext    = 64'($signed(rd_data_r));

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    cfg_hit       = 1'b0;
    if (cmd.cfg_en) begin
      unique case (cfg_index)
        spiral_pkg::REG_ROW_COUNT: begin
          row_count_nxt = clamp_count(cfg_data[CW-1:0], MAX_ROWS);
          cfg_hit       = 1'b1;
        end
        spiral_pkg::REG_COL_COUNT: begin
          col_count_nxt = clamp_count(cfg_data[CW-1:0], MAX_COLS);
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign rewind = cfg_hit || (cmd.load_en && full) || (cmd.walk_en && last);

  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    if (cfg_hit) begin
      load_row_nxt = '0;
      load_col_nxt = '0;
    end else if (cmd.load_en) begin
      if (wr_col + CW'(1) == col_count_r) begin
        load_col_nxt = '0;
        load_row_nxt = wr_row + CW'(1);
      end else begin
        load_col_nxt = wr_col + CW'(1);
        load_row_nxt = wr_row;
      end
    end
  end

  always_comb begin
    emitted_nxt   = emitted_r;
    walk_row_nxt  = walk_row_r;
    walk_col_nxt  = walk_col_r;
    dir_nxt       = dir_r;
    bnd_top_nxt   = bnd_top_r;
    bnd_bot_nxt   = bnd_bot_r;
    bnd_left_nxt  = bnd_left_r;
    bnd_right_nxt = bnd_right_r;
    if (rewind) begin
      emitted_nxt   = '0;
      walk_row_nxt  = '0;
      walk_col_nxt  = '0;
      dir_nxt       = DIR_RIGHT;
      bnd_top_nxt   = CW'(1);
      bnd_bot_nxt   = row_count_nxt - CW'(1);
      bnd_left_nxt  = '0;
      bnd_right_nxt = col_count_nxt - CW'(1);
    end else if (cmd.walk_en) begin
      emitted_nxt = emitted_r + TW'(1);
      case (dir_r)
        DIR_RIGHT: begin
          if (walk_col_r == bnd_right_r) begin
            dir_nxt       = DIR_DOWN;
            bnd_right_nxt = bnd_right_r - CW'(1);
            walk_row_nxt  = walk_row_r + CW'(1);
          end else begin
            walk_col_nxt = walk_col_r + CW'(1);
          end
        end
        DIR_DOWN: begin
          if (walk_row_r == bnd_bot_r) begin
            dir_nxt      = DIR_LEFT;
            bnd_bot_nxt  = bnd_bot_r - CW'(1);
            walk_col_nxt = walk_col_r - CW'(1);
          end else begin
            walk_row_nxt = walk_row_r + CW'(1);
          end
        end
        DIR_LEFT: begin
          if (walk_col_r == bnd_left_r) begin
            dir_nxt      = DIR_UP;
            bnd_left_nxt = bnd_left_r + CW'(1);
            walk_row_nxt = walk_row_r - CW'(1);
          end else begin
            walk_col_nxt = walk_col_r - CW'(1);
          end
        end
        default: begin
          if (walk_row_r == bnd_top_r) begin
            dir_nxt      = DIR_RIGHT;
            bnd_top_nxt  = bnd_top_r + CW'(1);
            walk_col_nxt = walk_col_r + CW'(1);
          end else begin
            walk_row_nxt = walk_row_r - CW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CW'(1);
      col_count_r <= CW'(1);
      load_row_r  <= '0;
      load_col_r  <= '0;
      emitted_r   <= '0;
      walk_row_r  <= '0;
      walk_col_r  <= '0;
      dir_r       <= DIR_RIGHT;
      bnd_top_r   <= CW'(1);
      bnd_bot_r   <= '0;
      bnd_left_r  <= '0;
      bnd_right_r <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      emitted_r   <= emitted_nxt;
      walk_row_r  <= walk_row_nxt;
      walk_col_r  <= walk_col_nxt;
      dir_r       <= dir_nxt;
      bnd_top_r   <= bnd_top_nxt;
      bnd_bot_r   <= bnd_bot_nxt;
      bnd_left_r  <= bnd_left_nxt;
      bnd_right_r <= bnd_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[wr_addr] <= in_wide[ELEMENT_BITS-1:0];
    end
    if (cmd.walk_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.miss_en) begin
      element_out  <= '0;
      row_index    <= '0;
      col_index    <= '0;
      last_element <= 1'b0;
      status       <= 1'b1;
    end else if (cmd.walk_en) begin
      row_index    <= walk_row_r[spiral_pkg::IDX_W-1:0];
      col_index    <= walk_col_r[spiral_pkg::IDX_W-1:0];
      last_element <= last;
      status       <= 1'b0;
    end
    if (cmd.capture_en) begin
      element_out <= rd_ext[EW-1:0];
    end
  end

endmodule

>>> test/tb_spiral_order_matrix_reader_core.sv
module tb_spiral_order_matrix_reader_core;
  import spiral_pkg::*;

  localparam int STORE_COLS = MAX_COLS_DEF;
  localparam int REQ_TARGET = 1550;
  localparam int RUN_LIMIT = 12_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;
  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_NOT_LOADED = 1'b1;

  typedef enum logic [1:0] {GO_RIGHT, GO_DOWN, GO_LEFT, GO_UP} heading_t;

  typedef struct {
    logic                     cmd;
    logic signed [ELEM_W-1:0] value;
  } request_t;

  typedef struct {
    logic signed [ELEM_W-1:0] element;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
    logic                     status;
  } spiral_result_t;

  logic clk = 1'b0;
  logic rst_n;

  spiral_in_if  in_if();
  spiral_out_if out_if();
  spiral_cfg_if cfg_if();

  spiral_order_matrix_reader_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  logic signed [ELEM_W-1:0] stored [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
  int n_rows, n_cols, fill_pos, walked;
  int at_row, at_col, top_b, bot_b, left_b, right_b;
  heading_t heading;

  request_t       request_q [$];
  spiral_result_t spiral_due [$];
  request_t       next_req;
  request_t       seen_req;
  spiral_result_t due_res;

  int sent_cnt = 0;
  int taken_cnt = 0;
  int queued_cnt = 0;
  int checked_cnt = 0;
  int fail_cnt = 0;
  int send_gap = 0;
  int stall_left = 0;
  int calm_in = 0;
  int calm_out = 0;

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_count(logic [CFG_DATA_W-1:0] data, int maxv);
    int v;
    v = data[COUNT_W-1:0];
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function void rewind_walk();
    walked = 0;
    at_row = 0;
    at_col = 0;
    heading = GO_RIGHT;
    top_b = 1;
    bot_b = n_rows - 1;
    left_b = 0;
    right_b = n_cols - 1;
  endfunction

  // Any count write throws the matrix away and rewinds the walker.
  function void spiral_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_ROW_COUNT) n_rows = clamp_count(data, MAX_ROWS_DEF);
    else if (idx == REG_COL_COUNT) n_cols = clamp_count(data, MAX_COLS_DEF);
    else return;
    fill_pos = 0;
    rewind_walk();
  endfunction

  function void spiral_predict(request_t req);
    spiral_result_t res;
    int total;
    total = n_rows * n_cols;
    if (req.cmd == CMD_LOAD) begin
      if (fill_pos >= total) begin
        fill_pos = 0;
        rewind_walk();
      end
      stored[(fill_pos / n_cols) * STORE_COLS + fill_pos % n_cols] = req.value;
      fill_pos++;
      return;
    end
    res.element = '0;
    res.row = '0;
    res.col = '0;
    res.last = 1'b0;
    res.status = STAT_NOT_LOADED;
    if (fill_pos >= total) begin
      res.element = stored[at_row * STORE_COLS + at_col];
      res.row = IDX_W'(at_row);
      res.col = IDX_W'(at_col);
      res.last = (walked + 1 >= total);
      res.status = STAT_OK;
      if (res.last) begin
        rewind_walk();
      end else begin
        walked++;
        case (heading)
          GO_RIGHT: begin
            if (at_col == right_b) begin
              heading = GO_DOWN;
              right_b--;
              at_row++;
            end else begin
              at_col++;
            end
          end
          GO_DOWN: begin
            if (at_row == bot_b) begin
              heading = GO_LEFT;
              bot_b--;
              at_col--;
            end else begin
              at_row++;
            end
          end
          GO_LEFT: begin
            if (at_col == left_b) begin
              heading = GO_UP;
              left_b++;
              at_row--;
            end else begin
              at_col--;
            end
          end
          default: begin
            if (at_row == top_b) begin
              heading = GO_RIGHT;
              top_b++;
              at_col++;
            end else begin
              at_row--;
            end
          end
        endcase
      end
    end
    spiral_due.insert(spiral_due.size(), res);
  endfunction

  function void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 19))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function void push_req(logic cmd, logic signed [ELEM_W-1:0] value);
    request_t req;
    req.cmd = cmd;
    req.value = value;
    request_q.insert(request_q.size(), req);
    queued_cnt++;
  endfunction

  function void load_elems(int n);
    repeat (n) push_req(CMD_LOAD, rand_elem());
  endfunction

  function void read_elems(int n);
    repeat (n) push_req(CMD_READ, $urandom);
  endfunction

  // Counts of 1 and 32 are sometimes written as 0 and as values above the maximum.
  function automatic logic [CFG_DATA_W-1:0] count_word(int n);
    logic [CFG_DATA_W-1:0] w;
    w = $urandom_range(0, 1) ? $urandom : '0;
    w[COUNT_W-1:0] = COUNT_W'(n);
    if (n == 1 && $urandom_range(0, 3) == 0) w[COUNT_W-1:0] = '0;
    if (n == MAX_ROWS_DEF && $urandom_range(0, 1) == 0) begin
      w[COUNT_W-1:0] = COUNT_W'($urandom_range(MAX_ROWS_DEF + 1, 63));
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Loads give no result, so the wait also holds until every sent request has been taken.
  task automatic wait_idle();
    while (request_q.size() != 0 || sent_cnt != taken_cnt || spiral_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (taken_cnt == sent_cnt) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (request_q.size() != 0) begin
        next_req = request_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.command <= next_req.cmd;
        in_if.element_in <= next_req.value;
        sent_cnt++;
        if (calm_in > 0) begin
          calm_in--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm_in = $urandom_range(20, 80);
        end else begin
          send_gap = gap_len();
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (calm_out > 0) begin
        calm_out--;
      end else if ($urandom_range(0, 99) < 2) begin
        calm_out = $urandom_range(30, 120);
      end else if ($urandom_range(0, 99) < 35) begin
        stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        checked_cnt++;
        if (spiral_due.size() == 0) begin
          note_failure($sformatf(
            "result %0d unexpected: elem %0d row %0d col %0d last %0b status %0b",
            checked_cnt, out_if.element_out, out_if.row_index, out_if.col_index,
            out_if.last_element, out_if.status));
        end else begin
          due_res = spiral_due.pop_front();
          if (out_if.element_out !== due_res.element || out_if.row_index !== due_res.row ||
              out_if.col_index !== due_res.col || out_if.last_element !== due_res.last ||
              out_if.status !== due_res.status) begin
            note_failure($sformatf(
              "result %0d mismatch: expected elem %0d row %0d col %0d last %0b status %0b, %s",
              checked_cnt, due_res.element, due_res.row, due_res.col, due_res.last,
              due_res.status,
              $sformatf("got elem %0d row %0d col %0d last %0b status %0b",
                        out_if.element_out, out_if.row_index, out_if.col_index,
                        out_if.last_element, out_if.status)));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen_req.cmd = in_if.command;
        seen_req.value = in_if.element_in;
        spiral_predict(seen_req);
        taken_cnt++;
      end
      if (cfg_if.valid && cfg_if.ready) spiral_config(cfg_if.index, cfg_if.data);
    end
  end

  initial begin
    int rows, cols, total, kind, part, pick;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.element_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    n_rows = 1;
    n_cols = 1;
    fill_pos = 0;
    rewind_walk();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The one by one matrix after reset: an early read, a load, repeated last elements,
    // and a load after completion that starts a new matrix.
    push_req(CMD_READ, 32'sh5a5a_5a5a);
    push_req(CMD_LOAD, 32'sh8000_0000);
    push_req(CMD_READ, '0);
    push_req(CMD_READ, '1);
    push_req(CMD_LOAD, 32'sh7fff_ffff);
    push_req(CMD_READ, '0);
    wait_idle();

    write_reg(REG_ROW_COUNT, {{(CFG_DATA_W-COUNT_W){1'b1}}, COUNT_W'(2)});
    write_reg(REG_COL_COUNT, CFG_DATA_W'(3));
    push_req(CMD_LOAD, '1);
    push_req(CMD_LOAD, '0);
    push_req(CMD_LOAD, 32'sh8000_0000);
    push_req(CMD_READ, '0);
    wait_idle();

    // Writes to unknown registers must leave the half loaded matrix alone.
    write_reg(REG_SPARE, CFG_DATA_W'(5));
    write_reg(REG_LAST_INDEX, '1);
    push_req(CMD_LOAD, 32'sh7fff_ffff);
    load_elems(2);
    read_elems(7);
    wait_idle();

    for (int p = 0; queued_cnt < REQ_TARGET; p++) begin
      if (p == 0) begin
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, CFG_DATA_W'(45));
      end else if (p == 1) begin
        write_reg(REG_COL_COUNT, CFG_DATA_W'(1));
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(MAX_ROWS_DEF));
      end else if (p == 2) begin
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(MAX_ROWS_DEF));
        write_reg(REG_COL_COUNT, CFG_DATA_W'(MAX_COLS_DEF));
      end else begin
        pick = $urandom_range(0, 99);
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 6);
        if (pick >= 92) begin
          rows = $urandom_range(1, 3);
          cols = $urandom_range(7, MAX_COLS_DEF);
        end else if (pick >= 80) begin
          rows = $urandom_range(7, MAX_ROWS_DEF);
          cols = $urandom_range(1, 3);
        end
        pick = $urandom_range(0, 9);
        if (pick != 0 && pick != 2) write_reg(REG_ROW_COUNT, count_word(rows));
        if (pick != 0 && pick != 1) write_reg(REG_COL_COUNT, count_word(cols));
        if ($urandom_range(0, 9) == 0) begin
          write_reg($urandom_range(0, 1) ? REG_SPARE : REG_LAST_INDEX, $urandom);
        end
      end
      total = n_rows * n_cols;
      kind = (p == 2) ? 90 : $urandom_range(0, 99);
      part = $urandom_range(0, total - 1);
      if (part > 40) part = $urandom_range(0, 40);
      if (kind < 60) begin
        load_elems(total);
        read_elems($urandom_range(total, 2 * total + 1));
      end else if (kind < 75) begin
        load_elems(part);
        read_elems($urandom_range(1, 3));
        load_elems(total - part);
        read_elems($urandom_range(total, 2 * total));
      end else if (kind < 87) begin
        load_elems(total);
        read_elems($urandom_range(0, total));
        load_elems(total);
        read_elems($urandom_range(total, 2 * total));
      end else if (kind < 94) begin
        load_elems(part);
        read_elems($urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 30)) begin
          push_req($urandom_range(0, 1) ? CMD_READ : CMD_LOAD, rand_elem());
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("spiral_order_matrix_reader_core test passed");
    end else begin
      $display("spiral_order_matrix_reader_core test failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("spiral_order_matrix_reader_core test failed");
    $finish;
  end

endmodule
